[src/brbs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and the operation code type for the circular byte buffer.
// Depends on nothing; the top level imports it.
package brbs_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int LANE_BYTES  = 8;

    // Store address, byte count, lane length, lane index, data, total and op code widths.
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int CNT_W   = $clog2(STORE_BYTES + 1);
    localparam int LEN_W   = $clog2(LANE_BYTES + 1);
    localparam int IDX_W   = $clog2(LANE_BYTES);
    localparam int DATA_W  = 8 * LANE_BYTES;
    localparam int TOTAL_W = 32;
    localparam int OP_W    = 3;

    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(STORE_BYTES);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(STORE_BYTES);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_POP        = 3'd1,
        OP_ADV_TAIL   = 3'd2,
        OP_SKIP_HEAD  = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_ZERO_TOTAL = 3'd5
    } op_t;

endpackage

[src/byte_ring_buffer_split_segments_unit.sv]
`timescale 1ns / 1ps
// Top level of the circular byte buffer: control, positions, counts and result register.
// Depends on brbs_pkg and on brbs_ram for the byte store.
//
//  channel | handshake             | word
//  --------+-----------------------+-----------------------------------------------
//  input   | in_valid / in_ready   | op, length, write_data
//  result  | out_valid / out_ready | accepted, read_data, counts, positions, total
//  config  | cfg_valid / cfg_ready | capacity_in_use
//
// The byte store is one RAM of one byte a word, so a push or a pop moves its bytes
// one at a time through the single RAM port, in S_PUSH or S_POP, and a pop then
// passes through S_DRAIN; every other operation goes from acceptance to S_FINISH.
// Reset empties the ring, zeroes the read total and sets the capacity to the full
// store; the store contents are not cleared. A result held by out_ready low stalls
// the block in S_FINISH until the result register is free.
module byte_ring_buffer_split_segments_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [brbs_pkg::OP_W-1:0]     op,
    input  logic [brbs_pkg::CNT_W-1:0]    length,
    input  logic [brbs_pkg::DATA_W-1:0]   write_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic [brbs_pkg::DATA_W-1:0]   read_data,
    output logic [brbs_pkg::CNT_W-1:0]    used_count,
    output logic [brbs_pkg::CNT_W-1:0]    front_used,
    output logic [brbs_pkg::CNT_W-1:0]    behind_used,
    output logic [brbs_pkg::CNT_W-1:0]    front_free,
    output logic [brbs_pkg::CNT_W-1:0]    behind_free,
    output logic [brbs_pkg::ADDR_W-1:0]   head_position,
    output logic [brbs_pkg::ADDR_W-1:0]   tail_position,
    output logic [brbs_pkg::TOTAL_W-1:0]  read_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [brbs_pkg::CNT_W-1:0]    capacity_in_use
);

    import brbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cap_reg;
    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    tail_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic                 ok_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [DATA_W-1:0]    wdata_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic                 rd_pend_reg;
    logic [IDX_W-1:0]     rd_idx_reg;

    logic                 out_valid_reg;
    logic                 accepted_reg;
    logic [DATA_W-1:0]    read_data_reg;
    logic [CNT_W-1:0]     used_count_reg;
    logic [CNT_W-1:0]     front_used_reg;
    logic [CNT_W-1:0]     behind_used_reg;
    logic [CNT_W-1:0]     front_free_reg;
    logic [CNT_W-1:0]     behind_free_reg;
    logic [ADDR_W-1:0]    head_position_reg;
    logic [ADDR_W-1:0]    tail_position_reg;
    logic [TOTAL_W-1:0]   read_total_reg;

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 out_free;
    logic [CNT_W-1:0]     space;
    logic                 len_nonzero;
    logic                 len_lane;
    logic                 op_ok;
    logic [LEN_W-1:0]     len_m1;
    logic                 last_byte;
    logic [CNT_W-1:0]     cap_limited;
    logic [CNT_W-1:0]     fu;
    logic [CNT_W-1:0]     bu;
    logic [CNT_W-1:0]     ff;
    logic [CNT_W-1:0]     bf;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [7:0]           ram_wdata;
    logic [7:0]           ram_rdata;

    // Adds n to a position and wraps once at the capacity; n never exceeds it.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] pos,
                                                   input logic [CNT_W-1:0]  n,
                                                   input logic [CNT_W-1:0]  cap);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, pos} + {1'b0, n};
        if (sum >= {1'b0, cap})
        begin
            sum = sum - {1'b0, cap};
        end
        if (sum >= {1'b0, cap})
        begin
            sum = '0;
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign space       = cap_reg - count_reg;
    assign len_nonzero = (length != '0);
    assign len_lane    = len_nonzero && (length <= CNT_W'(LANE_BYTES));

    always_comb
    begin
        case (op_t'(op))
            OP_PUSH:       op_ok = len_lane && (length <= space);
            OP_POP:        op_ok = len_lane && (length <= count_reg);
            OP_ADV_TAIL:   op_ok = len_nonzero && (length <= space);
            OP_SKIP_HEAD:  op_ok = len_nonzero && (length <= count_reg);
            OP_CLEAR:      op_ok = 1'b1;
            OP_ZERO_TOTAL: op_ok = 1'b1;
            default:       op_ok = 1'b0;
        endcase
    end

    assign len_m1    = len_reg - LEN_W'(1);
    assign last_byte = (idx_reg == len_m1[IDX_W-1:0]);

    always_comb
    begin
        if (capacity_in_use == '0)
        begin
            cap_limited = CNT_W'(1);
        end
        else if (capacity_in_use > CAP_MAX)
        begin
            cap_limited = CAP_MAX;
        end
        else
        begin
            cap_limited = capacity_in_use;
        end
    end

    // Segment sizes of the ring as it stands after the operation.
    always_comb
    begin
        if (count_reg == '0)
        begin
            fu = '0;
            bu = '0;
        end
        else if (tail_reg <= head_reg)
        begin
            fu = cap_reg - {1'b0, head_reg};
            bu = {1'b0, tail_reg};
        end
        else
        begin
            fu = count_reg;
            bu = '0;
        end

        if (count_reg >= cap_reg)
        begin
            ff = '0;
            bf = '0;
        end
        else if (tail_reg < head_reg)
        begin
            ff = {1'b0, head_reg} - {1'b0, tail_reg};
            bf = '0;
        end
        else
        begin
            ff = cap_reg - {1'b0, tail_reg};
            bf = {1'b0, head_reg};
        end
    end

    assign ram_we    = (state_reg == S_PUSH);
    assign ram_addr  = (state_reg == S_PUSH) ? tail_reg : head_reg;
    assign ram_wdata = wdata_reg[8 * idx_reg +: 8];

    brbs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cap_reg           <= CAP_RESET;
            head_reg          <= '0;
            tail_reg          <= '0;
            count_reg         <= '0;
            total_reg         <= '0;
            ok_reg            <= 1'b0;
            len_reg           <= '0;
            idx_reg           <= '0;
            wdata_reg         <= '0;
            rdata_reg         <= '0;
            rd_pend_reg       <= 1'b0;
            rd_idx_reg        <= '0;
            out_valid_reg     <= 1'b0;
            accepted_reg      <= 1'b0;
            read_data_reg     <= '0;
            used_count_reg    <= '0;
            front_used_reg    <= '0;
            behind_used_reg   <= '0;
            front_free_reg    <= '0;
            behind_free_reg   <= '0;
            head_position_reg <= '0;
            tail_position_reg <= '0;
            read_total_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // A read issued last cycle lands in its byte lane now.
            rd_pend_reg <= 1'b0;
            if (rd_pend_reg)
            begin
                rdata_reg[8 * rd_idx_reg +: 8] <= ram_rdata;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        cap_reg   <= cap_limited;
                        head_reg  <= '0;
                        tail_reg  <= '0;
                        count_reg <= '0;
                    end
                    else if (in_fire)
                    begin
                        ok_reg    <= op_ok;
                        len_reg   <= length[LEN_W-1:0];
                        idx_reg   <= '0;
                        wdata_reg <= write_data;
                        rdata_reg <= '0;
                        state_reg <= S_FINISH;
                        if (op_ok)
                        begin
                            case (op_t'(op))
                                OP_PUSH:
                                begin
                                    count_reg <= count_reg + length;
                                    state_reg <= S_PUSH;
                                end
                                OP_POP:
                                begin
                                    count_reg <= count_reg - length;
                                    total_reg <= total_reg + TOTAL_W'(length);
                                    state_reg <= S_POP;
                                end
                                OP_ADV_TAIL:
                                begin
                                    tail_reg  <= wrap_add(tail_reg, length, cap_reg);
                                    count_reg <= count_reg + length;
                                end
                                OP_SKIP_HEAD:
                                begin
                                    head_reg  <= wrap_add(head_reg, length, cap_reg);
                                    count_reg <= count_reg - length;
                                    total_reg <= total_reg + TOTAL_W'(length);
                                end
                                OP_CLEAR:
                                begin
                                    head_reg  <= '0;
                                    tail_reg  <= '0;
                                    count_reg <= '0;
                                end
                                OP_ZERO_TOTAL:
                                begin
                                    total_reg <= '0;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end

                S_PUSH:
                begin
                    tail_reg <= wrap_add(tail_reg, CNT_W'(1), cap_reg);
                    idx_reg  <= idx_reg + IDX_W'(1);
                    if (last_byte)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_POP:
                begin
                    head_reg    <= wrap_add(head_reg, CNT_W'(1), cap_reg);
                    idx_reg     <= idx_reg + IDX_W'(1);
                    rd_pend_reg <= 1'b1;
                    rd_idx_reg  <= idx_reg;
                    if (last_byte)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                S_DRAIN:
                begin
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        accepted_reg      <= ok_reg;
                        read_data_reg     <= rdata_reg;
                        used_count_reg    <= count_reg;
                        front_used_reg    <= fu;
                        behind_used_reg   <= bu;
                        front_free_reg    <= ff;
                        behind_free_reg   <= bf;
                        head_position_reg <= head_reg;
                        tail_position_reg <= tail_reg;
                        read_total_reg    <= total_reg;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign read_data     = read_data_reg;
    assign used_count    = used_count_reg;
    assign front_used    = front_used_reg;
    assign behind_used   = behind_used_reg;
    assign front_free    = front_free_reg;
    assign behind_free   = behind_free_reg;
    assign head_position = head_position_reg;
    assign tail_position = tail_position_reg;
    assign read_total    = read_total_reg;

endmodule

[src/brbs_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; the width and depth are set by the instantiating module.
module brbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
